FILE: rtl/core/ttpd_pkg.sv
`timescale 1ns / 1ps

package ttpd_pkg;

    // largest number of value bytes that may follow a long header
    localparam int unsigned MAX_VALUE_BYTES = 8;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_INT = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;
    localparam logic [1:0] ST_TRUNC   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_TENANT_MARKER   = 3'd0;
    localparam logic [2:0] CFG_INT_LOWEST_TAG  = 3'd1;
    localparam logic [2:0] CFG_INT_HIGHEST_TAG = 3'd2;
    localparam logic [2:0] CFG_INT_ZERO_TAG    = 3'd3;
    localparam logic [2:0] CFG_SMALL_LIMIT     = 3'd4;

    // one input beat
    typedef struct packed {
        logic [7:0] byte_in;
        logic       frame_end;
    } t_in_beat;

    // one result beat
    typedef struct packed {
        logic [63:0] table_id;
        logic [1:0]  status;
        logic        had_tenant;
        logic [4:0]  bytes_used;
    } t_out_beat;

    // register file contents seen by the decoder
    typedef struct packed {
        logic [7:0] tenant_marker;
        logic [7:0] int_lowest_tag;
        logic [7:0] int_highest_tag;
        logic [7:0] int_zero_tag;
        logic [7:0] small_limit;
    } t_cfg;

endpackage

FILE: rtl/core/ttpd_core.sv
`timescale 1ns / 1ps

module ttpd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttpd_pkg::t_cfg    i_cfg,
    input  logic              i_beat_en,
    input  ttpd_pkg::t_in_beat i_beat,
    output logic              o_res_valid,
    output ttpd_pkg::t_out_beat o_res
);
    import ttpd_pkg::*;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_TEN_HDR  = 3'd1,
        PH_TEN_BODY = 3'd2,
        PH_TBL_HDR  = 3'd3,
        PH_TBL_BODY = 3'd4,
        PH_SKIP     = 3'd5
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [3:0]   r_left, n_left;
    logic [63:0]  r_acc, n_acc;
    logic         r_seen, n_seen;
    logic [4:0]   r_cnt, n_cnt;

    logic [7:0]          b;
    logic                fe;
    logic                at_start;
    logic signed [10:0]  hdr_n;
    logic signed [10:0]  hdr_extra;
    logic                hdr_small;
    logic                hdr_too_long;
    logic                tag_bad;
    logic [3:0]          left_dec;
    logic [63:0]         acc_shift;
    logic [63:0]         res_value;
    logic [1:0]          res_status;

    assign b  = i_beat.byte_in;
    assign fe = i_beat.frame_end;

    // unknown phase codes behave as start of frame
    always_comb begin
        case (r_phase)
            PH_TEN_HDR, PH_TEN_BODY, PH_TBL_HDR, PH_TBL_BODY, PH_SKIP: at_start = 1'b0;
            default: at_start = 1'b1;
        endcase
    end

    // header arithmetic: signed length relative to the zero tag
    always_comb begin
        hdr_n        = $signed({3'b000, b}) - $signed({3'b000, i_cfg.int_zero_tag});
        hdr_extra    = hdr_n - $signed({3'b000, i_cfg.small_limit});
        hdr_small    = (hdr_n <= $signed({3'b000, i_cfg.small_limit}));
        hdr_too_long = (hdr_extra > $signed(11'(MAX_VALUE_BYTES)));
        tag_bad      = (b < i_cfg.int_lowest_tag) || (b > i_cfg.int_highest_tag);
        left_dec     = (r_left == 4'd0) ? 4'd0 : r_left - 4'd1;
        acc_shift    = {r_acc[55:0], b};
    end

    // per-beat decode step
    always_comb begin
        n_phase     = r_phase;
        n_left      = at_start ? 4'd0 : r_left;
        n_acc       = at_start ? 64'd0 : r_acc;
        n_seen      = at_start ? 1'b0 : r_seen;
        n_cnt       = (at_start ? 5'd0 : r_cnt) + 5'd1;
        o_res_valid = 1'b0;
        res_value   = 64'd0;
        res_status  = ST_OK;

        if (r_phase == PH_SKIP) begin
            n_cnt = r_cnt;
            if (fe) begin
                n_phase = PH_START;
            end
        end else if (at_start && (b == i_cfg.tenant_marker)) begin
            n_seen = 1'b1;
            if (fe) begin
                o_res_valid = 1'b1;
                res_status  = ST_TRUNC;
            end else begin
                n_phase = PH_TEN_HDR;
            end
        end else if (at_start || r_phase == PH_TBL_HDR) begin
            // table id header
            if (tag_bad) begin
                o_res_valid = 1'b1;
                res_status  = ST_NOT_INT;
            end else if (hdr_small) begin
                o_res_valid = 1'b1;
                res_status  = ST_OK;
                res_value   = {{53{hdr_n[10]}}, hdr_n};
            end else if (hdr_too_long) begin
                o_res_valid = 1'b1;
                res_status  = ST_BAD_LEN;
            end else if (fe) begin
                o_res_valid = 1'b1;
                res_status  = ST_TRUNC;
            end else begin
                n_left  = hdr_extra[3:0];
                n_acc   = 64'd0;
                n_phase = PH_TBL_BODY;
            end
        end else if (r_phase == PH_TEN_HDR) begin
            // tenant header, no tag range check
            if (hdr_small) begin
                if (fe) begin
                    o_res_valid = 1'b1;
                    res_status  = ST_TRUNC;
                end else begin
                    n_phase = PH_TBL_HDR;
                end
            end else if (hdr_too_long) begin
                o_res_valid = 1'b1;
                res_status  = ST_BAD_LEN;
            end else if (fe) begin
                o_res_valid = 1'b1;
                res_status  = ST_TRUNC;
            end else begin
                n_left  = hdr_extra[3:0];
                n_phase = PH_TEN_BODY;
            end
        end else if (r_phase == PH_TEN_BODY) begin
            // skip tenant value bytes
            n_left = left_dec;
            if (fe) begin
                o_res_valid = 1'b1;
                res_status  = ST_TRUNC;
            end else if (left_dec == 4'd0) begin
                n_phase = PH_TBL_HDR;
            end
        end else begin
            // table value bytes, big-endian
            n_acc  = acc_shift;
            n_left = left_dec;
            if (left_dec == 4'd0) begin
                o_res_valid = 1'b1;
                res_status  = ST_OK;
                res_value   = acc_shift;
            end else if (fe) begin
                o_res_valid = 1'b1;
                res_status  = ST_TRUNC;
            end
        end

        if (o_res_valid) begin
            n_phase = fe ? PH_START : PH_SKIP;
        end

        o_res.table_id   = res_value;
        o_res.status     = res_status;
        o_res.had_tenant = n_seen;
        o_res.bytes_used = n_cnt;
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_left  <= 4'd0;
            r_acc   <= 64'd0;
            r_seen  <= 1'b0;
            r_cnt   <= 5'd0;
        end else if (i_beat_en) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_acc   <= n_acc;
            r_seen  <= n_seen;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: rtl/core/tenant_table_prefix_decoder.sv
`timescale 1ns / 1ps

// Decodes the tenant and table prefix of a key streamed one byte per beat,
// with frame_end on the last byte. An optional tenant id (announced by the
// tenant marker byte) is skipped, then the table id varint is decoded, and
// exactly one result beat is produced per key: table id, status, tenant flag
// and byte count. Bytes after the result are dropped up to frame end. The
// decode state advances once per accepted byte and the result lands in a
// single output register, so a byte can be taken every cycle while the
// output side keeps up. Configuration writes belong between keys while
// the block is idle.
module tenant_table_prefix_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [2:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ttpd_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ttpd_pkg::t_out_beat  o_out_data
);
    import ttpd_pkg::*;

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_beat r_out;
    logic      in_fire;
    logic      res_valid;
    t_out_beat res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tenant_marker   <= 8'd254;
            r_cfg.int_lowest_tag  <= 8'd128;
            r_cfg.int_highest_tag <= 8'd253;
            r_cfg.int_zero_tag    <= 8'd136;
            r_cfg.small_limit     <= 8'd109;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TENANT_MARKER:   r_cfg.tenant_marker   <= i_cfg_wdata;
                CFG_INT_LOWEST_TAG:  r_cfg.int_lowest_tag  <= i_cfg_wdata;
                CFG_INT_HIGHEST_TAG: r_cfg.int_highest_tag <= i_cfg_wdata;
                CFG_INT_ZERO_TAG:    r_cfg.int_zero_tag    <= i_cfg_wdata;
                CFG_SMALL_LIMIT:     r_cfg.small_limit     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // take a beat whenever the output slot is empty or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    ttpd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_beat_en   (in_fire),
        .i_beat      (i_in_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // a failed decode never reports a table id
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> (o_out_data.table_id == 64'd0))
        else $error("nonzero table id on failed decode");

    // byte count stays within one key prefix
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.bytes_used != 5'd0 && o_out_data.bytes_used <= 5'd19))
        else $error("bytes used out of range");

    // a good result after a tenant prefix needs marker, tenant header and table header
    a_tenant_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.had_tenant && o_out_data.status == ST_OK)
            |-> (o_out_data.bytes_used >= 5'd3))
        else $error("ok tenant result with too few bytes");

    // a result only appears after an accepted beat
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_fire))
        else $error("result without input beat");
`endif

endmodule
